FILE: hdl/tnc2hp_pkg.sv
// ---------------------------------------------------------------------------
// TNC2 header parser package
// Transfer types, part tags, reject codes and callsign tables shared by the
// parser modules.
// ---------------------------------------------------------------------------
package tnc2hp_pkg;

   // Input transfer: one byte of the text line
   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_line;
   } req_type;

   // Result transfer: one per input byte
   typedef struct packed {
      logic [2:0] part_tag;
      logic       line_done;
      logic       line_ok;
      logic [2:0] reject_code;
   } rsp_type;

   // Line phase
   localparam logic [1:0] PH_SRC  = 2'd0;
   localparam logic [1:0] PH_DST  = 2'd1;
   localparam logic [1:0] PH_PATH = 2'd2;
   localparam logic [1:0] PH_INFO = 2'd3;

   // Part tags
   localparam logic [2:0] TAG_SRC  = 3'd0;
   localparam logic [2:0] TAG_DST  = 3'd1;
   localparam logic [2:0] TAG_PATH = 3'd2;
   localparam logic [2:0] TAG_INFO = 3'd3;
   localparam logic [2:0] TAG_SEP  = 3'd4;

   // Reject codes
   localparam logic [2:0] RC_OK       = 3'd0;
   localparam logic [2:0] RC_NO_GT    = 3'd1;
   localparam logic [2:0] RC_NO_COMMA = 3'd2;
   localparam logic [2:0] RC_NO_COLON = 3'd3;
   localparam logic [2:0] RC_BAD_LEN  = 3'd4;
   localparam logic [2:0] RC_RESERVED = 3'd5;
   localparam logic [2:0] RC_NO_INFO  = 3'd6;

   // Separator characters
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;

   // Source length limits and reserved-name compare depth
   localparam logic [3:0] SRC_LEN_MIN  = 4'd3;
   localparam logic [3:0] SRC_LEN_MAX  = 4'd9;
   localparam logic [3:0] SRC_LEN_SAT  = 4'd15;
   localparam logic [3:0] RSV_NAME_LEN = 4'd6;

   // Fold ASCII lower case to upper case; other bytes pass unchanged
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c inside {[8'h61:8'h7A]}) begin
         u = c - 8'h20;
      end
      return u;
   endfunction

   // Match of one folded byte against position idx of the reserved names.
   // Bit 0 N0CALL, bit 1 NOCALL, bit 2 MYCALL.
   function automatic logic [2:0] reserved_match(input logic [7:0] u,
                                                 input logic [2:0] idx);
      logic [2:0] m;
      case (idx)
         3'd0: begin
            m = {u == 8'h4D, u == 8'h4E, u == 8'h4E};
         end
         3'd1: begin
            m = {u == 8'h59, u == 8'h4F, u == 8'h30};
         end
         3'd2: begin
            m = {3{u == 8'h43}};
         end
         3'd3: begin
            m = {3{u == 8'h41}};
         end
         3'd4, 3'd5: begin
            m = {3{u == 8'h4C}};
         end
         default: begin
            m = 3'b000;
         end
      endcase
      return m;
   endfunction

endpackage

FILE: hdl/tnc2_header_parser_top.sv
// ---------------------------------------------------------------------------
// TNC2 header parser
// Tags each byte of a TNC2 packet line and gives a verdict on the last byte.
// ---------------------------------------------------------------------------
// One byte is taken per clock cycle while the result side keeps up, and each
// byte gives one result: the byte is registered, tagged and checked against
// the line state in one pass, and the result is registered. Throughput is set
// by the input and result registers alone, so bytes stream at full rate while
// the result side keeps up; a stall on the result side backs up through both
// registers. The line state clears after each byte flagged end_of_line.
module tnc2_header_parser_top
   import tnc2hp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    hold_valid;
   req_type hold_data;
   logic    load_ready;
   logic    advance;
   rsp_type result;

   // Move the held byte when the result register can take its result
   assign advance = hold_valid && load_ready;

   tnc2hp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   tnc2hp_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_data (hold_data),
      .result    (result)
   );

   tnc2hp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (hold_valid),
      .load_ready (load_ready),
      .load_data  (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hdl/tnc2hp_in_reg.sv
// ---------------------------------------------------------------------------
// TNC2 header parser input register
// Holds one accepted byte until the classify stage consumes it.
// ---------------------------------------------------------------------------
module tnc2hp_in_reg
   import tnc2hp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    take,
   output logic    hold_valid,
   output req_type hold_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // Accept when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on every input transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

FILE: hdl/tnc2hp_classify.sv
// ---------------------------------------------------------------------------
// TNC2 header parser classify stage
// Tags one byte, tracks the line state and forms the verdict on the last byte.
// ---------------------------------------------------------------------------
module tnc2hp_classify
   import tnc2hp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type byte_data,
   output rsp_type result
);

   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic [3:0] src_len_ff;
   logic [3:0] src_len_in;
   logic [2:0] rsv_flags_ff;
   logic [2:0] rsv_flags_in;
   logic       info_seen_ff;
   logic       info_seen_in;

   // Next line state and tag for this byte
   always_comb begin
      logic [1:0] ph_nx;
      logic [3:0] len_nx;
      logic [2:0] flg_nx;
      logic       inf_nx;
      logic [2:0] tag;
      logic [2:0] code;

      ph_nx  = phase_ff;
      len_nx = src_len_ff;
      flg_nx = rsv_flags_ff;
      inf_nx = info_seen_ff;
      tag    = TAG_INFO;
      code   = RC_OK;

      case (phase_ff)
         PH_SRC: begin
            if (byte_data.char_in == CH_GT) begin
               tag   = TAG_SEP;
               ph_nx = PH_DST;
            end else begin
               tag = TAG_SRC;
               if (src_len_ff < RSV_NAME_LEN) begin
                  flg_nx = rsv_flags_ff &
                           reserved_match(fold_upper(byte_data.char_in),
                                          src_len_ff[2:0]);
               end
               if (src_len_ff != SRC_LEN_SAT) begin
                  len_nx = src_len_ff + 4'd1;
               end
            end
         end
         PH_DST: begin
            if (byte_data.char_in == CH_COMMA) begin
               tag   = TAG_SEP;
               ph_nx = PH_PATH;
            end else begin
               tag = TAG_DST;
            end
         end
         PH_PATH: begin
            if (byte_data.char_in == CH_COLON) begin
               tag   = TAG_SEP;
               ph_nx = PH_INFO;
            end else begin
               tag = TAG_PATH;
            end
         end
         default: begin
            tag    = TAG_INFO;
            inf_nx = 1'b1;
         end
      endcase

      // Verdict from the state reached after this byte, first failure wins
      if (ph_nx == PH_SRC) begin
         code = RC_NO_GT;
      end else if (ph_nx == PH_DST) begin
         code = RC_NO_COMMA;
      end else if (ph_nx == PH_PATH) begin
         code = RC_NO_COLON;
      end else if (len_nx < SRC_LEN_MIN || len_nx > SRC_LEN_MAX) begin
         code = RC_BAD_LEN;
      end else if (len_nx >= RSV_NAME_LEN && flg_nx != 3'b000) begin
         code = RC_RESERVED;
      end else if (!inf_nx) begin
         code = RC_NO_INFO;
      end

      result.part_tag = tag;
      result.line_done = byte_data.end_of_line;
      if (byte_data.end_of_line) begin
         result.line_ok     = (code == RC_OK);
         result.reject_code = code;
         // Clear state for the next line
         phase_in     = PH_SRC;
         src_len_in   = 4'd0;
         rsv_flags_in = 3'b111;
         info_seen_in = 1'b0;
      end else begin
         result.line_ok     = 1'b0;
         result.reject_code = RC_OK;
         phase_in     = ph_nx;
         src_len_in   = len_nx;
         rsv_flags_in = flg_nx;
         info_seen_in = inf_nx;
      end
   end

   // Advance line state once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SRC;
         src_len_ff   <= 4'd0;
         rsv_flags_ff <= 3'b111;
         info_seen_ff <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         src_len_ff   <= src_len_in;
         rsv_flags_ff <= rsv_flags_in;
         info_seen_ff <= info_seen_in;
      end
   end

endmodule

FILE: hdl/tnc2hp_out_reg.sv
// ---------------------------------------------------------------------------
// TNC2 header parser result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module tnc2hp_out_reg
   import tnc2hp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_valid,
   output logic    load_ready,
   input  rsp_type load_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or when the held result transfers this cycle
   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = (load_valid && load_ready) || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hdl/tnc2hp_checker.sv
// ---------------------------------------------------------------------------
// TNC2 header parser checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module tnc2hp_checker
   import tnc2hp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Keep verdict fields clear away from the last byte
   a_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.line_done |->
         !rsp_data.line_ok && rsp_data.reject_code == RC_OK)
      else $error("verdict on a byte that is not last");

   // Accept a line only with a clear reject code
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_done |->
         rsp_data.line_ok == (rsp_data.reject_code == RC_OK))
      else $error("line_ok disagrees with reject_code");

   // A rising result must follow an input transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching input transfer");

endmodule

bind tnc2_header_parser_top tnc2hp_checker u_checker (.*);
